// ===== hdl/cfa_pkg.sv =====
// Package for the contiguous frame allocator: payload structs, codes, state
// machine encoding and default sizes. Used by the allocator core and the testbench.
// No dependencies.
package cfa_pkg;

    localparam int MAX_FRAMES_DEF = 512;

    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 10'd512;

    // Per-frame state codes
    localparam logic [1:0] FS_FREE = 2'b00;
    localparam logic [1:0] FS_USED = 2'b01;
    localparam logic [1:0] FS_HEAD = 2'b11;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_REL   = 2'd1,
        OP_MARK  = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_BAD_COUNT = 3'd1,
        STS_NO_RUN    = 3'd2,
        STS_RANGE     = 3'd3,
        STS_NOT_HEAD  = 3'd4
    } sts_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE    = 2'd0,
        CFG_FRAMES  = 2'd1,
        CFG_RESERVE = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FILL,
        S_REL,
        S_MARK,
        S_INIT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        op_t                opcode;
        logic [FRAME_W-1:0] frame_number;
        logic [COUNT_W-1:0] count;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] alloc_frame;
        sts_t               status;
        logic [COUNT_W-1:0] free_frames;
    } out_item_t;

endpackage

// ===== hdl/contiguous_frame_allocator_core.sv =====
// Contiguous frame allocator: first-fit allocator over a 2-bit frame state store.
// One item at a time; each walk step reads and writes the store once (1R1W store).
// Reset clears control, then sweeps the store to free one frame a cycle; no item is
// taken meanwhile, configuration writes are.
module contiguous_frame_allocator_core #(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  cfa_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cfa_pkg::out_item_t                 out_data,
    input  logic                               cfg_write,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int XW = (CW > cfa_pkg::COUNT_W) ? CW : cfa_pkg::COUNT_W;
    localparam int AW = ((CW > cfa_pkg::FRAME_W) ? CW : cfa_pkg::FRAME_W) + 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FRAMES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_FRAMES);

    // Configuration
    logic [cfa_pkg::FRAME_W-1:0] base_reg;
    logic [cfa_pkg::COUNT_W-1:0] fiu_reg;
    logic                        resv_reg;

    // Sequencer
    cfa_pkg::seq_state_t         state_reg, state_next;
    cfa_pkg::op_t                op_reg, op_next;
    logic [cfa_pkg::FRAME_W-1:0] fno_reg, fno_next;
    logic [cfa_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic [CW-1:0]               ev_reg, ev_next;
    logic                        vld_reg, vld_next;
    logic [cfa_pkg::COUNT_W-1:0] run_reg, run_next;
    logic [CW-1:0]               start_reg, start_next;
    logic [CW-1:0]               limit_reg, limit_next;
    logic                        first_reg, first_next;
    cfa_pkg::sts_t               status_reg, status_next;
    logic [cfa_pkg::FRAME_W-1:0] ff_reg, ff_next;
    logic [CW-1:0]               free_cnt_reg, free_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    cfa_pkg::out_item_t          out_data_reg, out_data_next;

    // Store port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic [1:0]    ram_rdata;

    // Shared datapath terms
    logic [CW-1:0]               pool_n;
    logic [XW-1:0]               fiu_x;
    logic [cfa_pkg::FRAME_W:0]   off_full;
    logic                        below_base;
    logic [AW-1:0]               off_x;
    logic [AW-1:0]               end_x;
    logic                        issue;
    logic                        ev_last;
    logic                        run_hit;
    logic                        ptr_last;
    logic [CW-1:0]               cnt_up;
    logic [CW-1:0]               cnt_down;

    cfa_state_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign fiu_x      = XW'(fiu_reg);
    assign pool_n     = (fiu_x < XW'(MAX_FRAMES)) ? CW'(fiu_x) : MAX_CNT;
    assign off_full   = {1'b0, fno_reg} - {1'b0, base_reg};
    assign below_base = off_full[cfa_pkg::FRAME_W];
    assign off_x      = AW'(off_full[cfa_pkg::FRAME_W-1:0]);
    assign end_x      = off_x + AW'(cnt_reg);
    assign issue      = (ptr_reg < limit_reg);
    assign ev_last    = ((ev_reg + CW'(1)) == limit_reg);
    assign ptr_last   = ((ptr_reg + CW'(1)) == limit_reg);
    assign run_hit    = (({1'b0, run_reg} + 11'd1) == {1'b0, cnt_reg});
    assign cnt_up     = (free_cnt_reg < MAX_CNT) ? (free_cnt_reg + CW'(1)) : free_cnt_reg;
    assign cnt_down   = (free_cnt_reg != '0) ? (free_cnt_reg - CW'(1)) : free_cnt_reg;

    assign in_stall  = (state_reg != cfa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            fiu_reg  <= cfa_pkg::FRAMES_IN_USE_RST;
            resv_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cfa_pkg::CFG_BASE:    base_reg <= cfg_data[cfa_pkg::FRAME_W-1:0];
                cfa_pkg::CFG_FRAMES:  fiu_reg  <= cfg_data[cfa_pkg::COUNT_W-1:0];
                cfa_pkg::CFG_RESERVE: resv_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfa_pkg::S_CLEAR;
            ptr_reg       <= '0;
            vld_reg       <= 1'b0;
            free_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            vld_reg       <= vld_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        fno_reg      <= fno_next;
        cnt_reg      <= cnt_next;
        ev_reg       <= ev_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        limit_reg    <= limit_next;
        first_reg    <= first_next;
        status_reg   <= status_next;
        ff_reg       <= ff_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        fno_next       = fno_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        ev_next        = ev_reg;
        vld_next       = vld_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        limit_next     = limit_reg;
        first_next     = first_reg;
        status_next    = status_reg;
        ff_next        = ff_reg;
        free_cnt_next  = free_cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = ev_reg[IW-1:0];
        ram_wdata      = cfa_pkg::FS_FREE;

        // Streaming read: issue the next address while the previous one returns
        if (state_reg == cfa_pkg::S_SCAN || state_reg == cfa_pkg::S_REL ||
            state_reg == cfa_pkg::S_MARK)
        begin
            vld_next = issue;
            if (issue)
            begin
                ptr_next = ptr_reg + CW'(1);
                ev_next  = ptr_reg;
            end
        end

        unique case (state_reg)
            cfa_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IW-1:0];
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = cfa_pkg::S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            cfa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    fno_next   = in_data.frame_number;
                    cnt_next   = in_data.count;
                    state_next = cfa_pkg::S_CHECK;
                end
            end

            cfa_pkg::S_CHECK:
            begin
                ff_next     = '0;
                status_next = cfa_pkg::STS_OK;
                vld_next    = 1'b0;
                run_next    = '0;
                first_next  = 1'b1;
                state_next  = cfa_pkg::S_DONE;
                unique case (op_reg)
                    cfa_pkg::OP_ALLOC:
                    begin
                        if (cnt_reg == '0 || XW'(cnt_reg) > XW'(free_cnt_reg))
                        begin
                            status_next = cfa_pkg::STS_BAD_COUNT;
                        end
                        else if (pool_n == '0)
                        begin
                            status_next = cfa_pkg::STS_NO_RUN;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            limit_next = pool_n;
                            state_next = cfa_pkg::S_SCAN;
                        end
                    end
                    cfa_pkg::OP_REL:
                    begin
                        if (below_base || off_x >= AW'(pool_n))
                        begin
                            status_next = cfa_pkg::STS_RANGE;
                        end
                        else
                        begin
                            ptr_next   = CW'(off_x);
                            limit_next = pool_n;
                            state_next = cfa_pkg::S_REL;
                        end
                    end
                    cfa_pkg::OP_MARK:
                    begin
                        if (below_base || end_x > AW'(pool_n))
                        begin
                            status_next = cfa_pkg::STS_RANGE;
                        end
                        else if (cnt_reg != '0)
                        begin
                            ptr_next   = CW'(off_x);
                            limit_next = CW'(end_x);
                            state_next = cfa_pkg::S_MARK;
                        end
                    end
                    cfa_pkg::OP_INIT:
                    begin
                        if (pool_n == '0)
                        begin
                            free_cnt_next = '0;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            limit_next = pool_n;
                            state_next = cfa_pkg::S_INIT;
                        end
                    end
                    default: ;
                endcase
            end

            cfa_pkg::S_SCAN:
            begin
                if (vld_reg)
                begin
                    if (ram_rdata == cfa_pkg::FS_FREE)
                    begin
                        run_next = run_reg + 10'd1;
                        if (run_reg == '0)
                        begin
                            start_next = ev_reg;
                        end
                        if (run_hit)
                        begin
                            // Run found: go back and claim it
                            ptr_next   = (run_reg == '0) ? ev_reg : start_reg;
                            start_next = (run_reg == '0) ? ev_reg : start_reg;
                            run_next   = '0;
                            vld_next   = 1'b0;
                            state_next = cfa_pkg::S_FILL;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    if (!(ram_rdata == cfa_pkg::FS_FREE && run_hit) && ev_last)
                    begin
                        status_next = cfa_pkg::STS_NO_RUN;
                        vld_next    = 1'b0;
                        state_next  = cfa_pkg::S_DONE;
                    end
                end
            end

            cfa_pkg::S_FILL:
            begin
                ram_we        = 1'b1;
                ram_waddr     = ptr_reg[IW-1:0];
                ram_wdata     = (run_reg == '0) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
                free_cnt_next = cnt_down;
                ptr_next      = ptr_reg + CW'(1);
                run_next      = run_reg + 10'd1;
                if (run_hit)
                begin
                    ff_next    = base_reg + cfa_pkg::FRAME_W'(start_reg);
                    state_next = cfa_pkg::S_DONE;
                end
            end

            cfa_pkg::S_REL:
            begin
                if (vld_reg)
                begin
                    if (first_reg && ram_rdata != cfa_pkg::FS_HEAD)
                    begin
                        status_next = cfa_pkg::STS_NOT_HEAD;
                        vld_next    = 1'b0;
                        state_next  = cfa_pkg::S_DONE;
                    end
                    else if (first_reg || ram_rdata == cfa_pkg::FS_USED)
                    begin
                        ram_we        = 1'b1;
                        free_cnt_next = cnt_up;
                        first_next    = 1'b0;
                        if (ev_last)
                        begin
                            vld_next   = 1'b0;
                            state_next = cfa_pkg::S_DONE;
                        end
                    end
                    else
                    begin
                        vld_next   = 1'b0;
                        state_next = cfa_pkg::S_DONE;
                    end
                end
            end

            cfa_pkg::S_MARK:
            begin
                if (vld_reg)
                begin
                    if (ram_rdata == cfa_pkg::FS_FREE)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = (run_reg == '0) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
                        free_cnt_next = cnt_down;
                    end
                    run_next = run_reg + 10'd1;
                    if (ev_last)
                    begin
                        vld_next   = 1'b0;
                        state_next = cfa_pkg::S_DONE;
                    end
                end
            end

            cfa_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IW-1:0];
                ram_wdata = (ptr_reg == '0 && resv_reg) ? cfa_pkg::FS_USED : cfa_pkg::FS_FREE;
                ptr_next  = ptr_reg + CW'(1);
                if (ptr_last)
                begin
                    free_cnt_next = resv_reg ? (pool_n - CW'(1)) : pool_n;
                    state_next    = cfa_pkg::S_DONE;
                end
            end

            cfa_pkg::S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.alloc_frame = ff_reg;
                    out_data_next.status      = status_reg;
                    out_data_next.free_frames = cfa_pkg::COUNT_W'(free_cnt_reg);
                    out_valid_next            = 1'b1;
                    state_next                = cfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cfa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cfa_pkg::S_DONE))
        else $error("result transfer raised outside completion");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfa_pkg::S_SCAN) |-> !ram_we)
        else $error("frame store written during first-fit search");

    a_walk_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cfa_pkg::S_REL || state_reg == cfa_pkg::S_MARK) && ram_we) |-> vld_reg)
        else $error("walk wrote without returned read data");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == cfa_pkg::S_CLEAR) && state_reg != cfa_pkg::S_CLEAR)
        |-> $past(ptr_reg) == LAST_IDX)
        else $error("clearing pass left before the last frame");

    a_not_head_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfa_pkg::S_DONE && status_reg == cfa_pkg::STS_NOT_HEAD)
        |-> op_reg == cfa_pkg::OP_REL)
        else $error("not-head status on an item other than release");

    a_frame_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.alloc_frame != '0)
        |-> out_data_reg.status == cfa_pkg::STS_OK)
        else $error("first frame reported on a failed item");
`endif

endmodule

// ===== hdl/cfa_state_ram.sv =====
// Frame state store: one write port and one read port with registered read data.
// Depends on nothing; sized by the top level.
module cfa_state_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== sim/tb_contiguous_frame_allocator_core.sv =====
// Self-checking testbench for contiguous_frame_allocator_core: directed and random
// allocate, release, mark and initialize transfers checked against an in-bench predictor.
// Depends on hdl/cfa_pkg.sv and hdl/contiguous_frame_allocator_core.sv.
module tb_contiguous_frame_allocator_core;

    localparam int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    cfa_pkg::in_item_t              in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    cfa_pkg::out_item_t             out_data;
    logic                           cfg_write = 1'b0;
    logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: frame map, free tally and the pool registers
    logic [1:0]   frame_map [MAX_FRAMES];
    int unsigned  free_tally = 0;
    logic [19:0]  pool_base = '0;
    logic [9:0]   pool_frames = cfa_pkg::FRAMES_IN_USE_RST;
    logic         reserve_zero = 1'b0;

    cfa_pkg::out_item_t awaited_outcomes [$];
    int unsigned  mismatch_count = 0;
    int unsigned  hold_req = 0;
    bit           no_idle = 1'b0;

    contiguous_frame_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #100000000;
        $display("contiguous_frame_allocator_core regression: fail");
        $finish;
    end

    function automatic int unsigned pool_len();
        return (pool_frames < MAX_FRAMES) ? pool_frames : MAX_FRAMES;
    endfunction

    function automatic void tally_down();
        if (free_tally > 0)
            free_tally--;
    endfunction

    function automatic void tally_up();
        if (free_tally < MAX_FRAMES)
            free_tally++;
    endfunction

    function automatic cfa_pkg::out_item_t predict_frame_op(input cfa_pkg::in_item_t item);
        cfa_pkg::out_item_t res;
        int unsigned n, cnt, fno, top, start, run, idx, i;
        n = pool_len();
        cnt = item.count;
        fno = item.frame_number;
        top = pool_base + n;
        res.alloc_frame = '0;
        res.status = cfa_pkg::STS_OK;
        case (item.opcode)
            cfa_pkg::OP_ALLOC:
            begin
                if (cnt == 0 || cnt > free_tally)
                    res.status = cfa_pkg::STS_BAD_COUNT;
                else
                begin
                    start = 0;
                    run = 0;
                    // first fit: stop as soon as the run is long enough
                    for (i = 0; i < n && run != cnt; i++)
                    begin
                        if (frame_map[i] == cfa_pkg::FS_FREE)
                        begin
                            if (run == 0)
                                start = i;
                            run++;
                        end
                        else
                            run = 0;
                    end
                    if (run != cnt)
                        res.status = cfa_pkg::STS_NO_RUN;
                    else
                    begin
                        for (i = 0; i < cnt; i++)
                        begin
                            frame_map[start + i] = (i == 0) ? cfa_pkg::FS_HEAD
                                                            : cfa_pkg::FS_USED;
                            tally_down();
                        end
                        res.alloc_frame = 20'(start + pool_base);
                    end
                end
            end
            cfa_pkg::OP_REL:
            begin
                if (fno < pool_base || fno >= top)
                    res.status = cfa_pkg::STS_RANGE;
                else
                begin
                    idx = fno - pool_base;
                    if (frame_map[idx] != cfa_pkg::FS_HEAD)
                        res.status = cfa_pkg::STS_NOT_HEAD;
                    else
                    begin
                        frame_map[idx] = cfa_pkg::FS_FREE;
                        tally_up();
                        idx++;
                        while (idx < n && frame_map[idx] == cfa_pkg::FS_USED)
                        begin
                            frame_map[idx] = cfa_pkg::FS_FREE;
                            tally_up();
                            idx++;
                        end
                    end
                end
            end
            cfa_pkg::OP_MARK:
            begin
                if (fno < pool_base || fno + cnt > top)
                    res.status = cfa_pkg::STS_RANGE;
                else
                begin
                    idx = fno - pool_base;
                    // only free frames are claimed; the first one becomes head
                    for (i = 0; i < cnt; i++)
                    begin
                        if (frame_map[idx + i] == cfa_pkg::FS_FREE)
                        begin
                            frame_map[idx + i] = (i == 0) ? cfa_pkg::FS_HEAD
                                                          : cfa_pkg::FS_USED;
                            tally_down();
                        end
                    end
                end
            end
            default:
            begin
                for (i = 0; i < n; i++)
                    frame_map[i] = cfa_pkg::FS_FREE;
                free_tally = n;
                if (reserve_zero && n > 0)
                begin
                    frame_map[0] = cfa_pkg::FS_USED;
                    free_tally--;
                end
            end
        endcase
        res.free_frames = 10'(free_tally);
        return res;
    endfunction

    function automatic cfa_pkg::in_item_t make_op(input cfa_pkg::op_t op,
                                                  input logic [19:0] fno,
                                                  input logic [9:0] cnt);
        cfa_pkg::in_item_t item;
        item.opcode = op;
        item.frame_number = fno;
        item.count = cnt;
        return item;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    function automatic logic [9:0] pick_count(input int unsigned cap);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (cap == 0)
            cap = 1;
        if (r < 7)
            return 10'($urandom_range(1, (cap < 6) ? cap : 6));
        if (r < 9)
            return 10'($urandom_range(0, cap));
        return 10'($urandom);
    endfunction

    // Mostly well-formed traffic: releases of live heads, marks inside the pool
    function automatic cfa_pkg::in_item_t compose_random_op();
        cfa_pkg::in_item_t item;
        int unsigned n, r, idx;
        int unsigned heads [$];
        n = pool_len();
        r = $urandom_range(0, 99);
        item = make_op(cfa_pkg::OP_ALLOC, 20'($urandom), 10'($urandom));
        if (r < 40)
            item.count = pick_count(n);
        else if (r < 75)
        begin
            item.opcode = cfa_pkg::OP_REL;
            for (idx = 0; idx < n; idx++)
                if (frame_map[idx] == cfa_pkg::FS_HEAD)
                    heads.push_back(idx);
            if (heads.size() != 0 && r < 65)
                item.frame_number = 20'(pool_base + heads[$urandom_range(0, heads.size() - 1)]);
            else if (n != 0 && r < 72)
                item.frame_number = 20'(pool_base + $urandom_range(0, n - 1));
        end
        else if (r < 93)
        begin
            item.opcode = cfa_pkg::OP_MARK;
            if (n != 0 && r < 90)
            begin
                idx = $urandom_range(0, n - 1);
                item.frame_number = 20'(pool_base + idx);
                item.count = pick_count(n - idx);
            end
        end
        else
            item.opcode = cfa_pkg::OP_INIT;
        return item;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endfunction

    // Offer one request; valid stays high when the next one follows without a gap
    task automatic send_op(input cfa_pkg::in_item_t item);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            in_data <= cfa_pkg::in_item_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_outcomes.push_back(predict_frame_op(item));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure_pool(input logic [19:0] base, input logic [9:0] frames,
                                  input logic reserve);
        cfg_write <= 1'b1;
        cfg_index <= cfa_pkg::CFG_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= cfa_pkg::CFG_FRAMES;
        cfg_data <= cfa_pkg::CFG_DATA_W'(frames);
        @(posedge clk);
        cfg_index <= cfa_pkg::CFG_RESERVE;
        cfg_data <= cfa_pkg::CFG_DATA_W'(reserve);
        @(posedge clk);
        cfg_write <= 1'b0;
        pool_base = base;
        pool_frames = frames;
        reserve_zero = reserve;
    endtask

    // The free tally is still zero before the first initialize and must not wrap
    task automatic test_before_init();
        configure_pool('0, 10'd512, 1'b0);
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd1));
        send_op(make_op(cfa_pkg::OP_MARK, 20'd500, 10'd12));
        send_op(make_op(cfa_pkg::OP_REL, 20'd501, '0));
        send_op(make_op(cfa_pkg::OP_REL, 20'd500, '0));
        wait_drained();
    endtask

    task automatic test_boundaries();
        logic [19:0] b;
        b = 20'hFFE00;
        configure_pool(b, 10'd512, 1'b1);
        send_op(make_op(cfa_pkg::OP_INIT, '0, '0));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd0));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd1023));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd511));
        send_op(make_op(cfa_pkg::OP_REL, b, '0));
        send_op(make_op(cfa_pkg::OP_REL, b + 20'd1, '0));
        send_op(make_op(cfa_pkg::OP_REL, b - 20'd1, '0));
        send_op(make_op(cfa_pkg::OP_MARK, b + 20'd10, 10'd5));
        send_op(make_op(cfa_pkg::OP_MARK, b + 20'd500, 10'd12));
        send_op(make_op(cfa_pkg::OP_MARK, b + 20'd500, 10'd13));
        send_op(make_op(cfa_pkg::OP_MARK, b + 20'd5, 10'd0));
        // enough frames free in total, but split into two shorter runs
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd490));
        send_op(make_op(cfa_pkg::OP_REL, b + 20'd10, '0));
        wait_drained();
    endtask

    task automatic test_wrap_and_empty_pool();
        // second allocation wraps past the top of the frame numbering
        configure_pool(20'hFFFFF, 10'd4, 1'b0);
        send_op(make_op(cfa_pkg::OP_INIT, '0, '0));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd2));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd2));
        send_op(make_op(cfa_pkg::OP_REL, 20'hFFFFF, '0));
        send_op(make_op(cfa_pkg::OP_REL, 20'd1, '0));
        send_op(make_op(cfa_pkg::OP_MARK, 20'hFFFFF, 10'd1023));
        wait_drained();
        configure_pool(20'hFFFFF, 10'd0, 1'b1);
        send_op(make_op(cfa_pkg::OP_INIT, '0, '0));
        send_op(make_op(cfa_pkg::OP_ALLOC, '0, 10'd1));
        send_op(make_op(cfa_pkg::OP_REL, 20'hFFFFF, '0));
        send_op(make_op(cfa_pkg::OP_MARK, 20'hFFFFF, 10'd0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        configure_pool(20'h00040, 10'd32, 1'b0);
        send_op(make_op(cfa_pkg::OP_INIT, '0, '0));
        hold_req <= 300;
        no_idle = 1'b1;
        repeat (12) send_op(compose_random_op());
        no_idle = 1'b0;
        wait_drained();
        repeat (12) send_op(compose_random_op());
        wait_drained();
    endtask

    task automatic test_random_phases();
        int unsigned sizes [14] = '{16, 64, 8, 512, 32, 1, 64, 700, 24, 0, 48, 512, 16, 128};
        int unsigned p, k, batch;
        logic [19:0] base;
        for (p = 0; p < 14; p++)
        begin
            base = 20'($urandom);
            if (p == 3)
                base = '0;
            if (p == 7)
                base = 20'hFFFFF;
            if (p == 11)
                base = 20'hFFF00;
            configure_pool(base, 10'(sizes[p]), 1'($urandom_range(0, 1)));
            no_idle = (p == 4);
            // now and then keep the old frame map across a register change
            if ($urandom_range(0, 5) != 0)
                send_op(make_op(cfa_pkg::OP_INIT, '0, '0));
            batch = (sizes[p] >= 512) ? 40 : 90;
            for (k = 0; k < batch; k++)
                send_op(compose_random_op());
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_stall
        int unsigned span;
        forever
        begin
            @(posedge clk);
            span = 0;
            if (hold_req != 0)
            begin
                span = hold_req;
                hold_req <= 0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
                span = pick_gap() + 1;
            if (span != 0)
            begin
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin : result_check
        cfa_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (awaited_outcomes.size() == 0)
                    report_mismatch("unrequested result", '0, 32'(out_data.free_frames));
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (out_data.alloc_frame !== want.alloc_frame)
                        report_mismatch("alloc_frame", 32'(want.alloc_frame),
                                        32'(out_data.alloc_frame));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(out_data.status));
                    if (out_data.free_frames !== want.free_frames)
                        report_mismatch("free_frames", 32'(want.free_frames),
                                        32'(out_data.free_frames));
                end
            end
        end
    end

    initial
    begin : regression
        int unsigned f;
        for (f = 0; f < MAX_FRAMES; f++)
            frame_map[f] = cfa_pkg::FS_FREE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_before_init();
        test_boundaries();
        test_wrap_and_empty_pool();
        test_backpressure();
        test_random_phases();
        wait_drained();
        // allow the longest walk to finish in case a stray result follows
        repeat (1100) @(posedge clk);
        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("contiguous_frame_allocator_core regression: pass");
        else
            $display("contiguous_frame_allocator_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cfa_pkg.sv
hdl/cfa_state_ram.sv
hdl/contiguous_frame_allocator_core.sv
sim/tb_contiguous_frame_allocator_core.sv
